// ===== rtl/core/tlsc_pkg.sv =====
// Package for the timestamp LRU slot cache.
// Holds item kinds, sequencer states, the slot row type and default sizes.
// No dependencies.
`timescale 1ns / 1ps

package tlsc_pkg;

  localparam int unsigned SlotsDef  = 16;
  localparam logic [7:0]  FadeReset = 8'd22;
  localparam logic [7:0]  FadeMax   = 8'd255;

  typedef enum logic [2:0] {
    KIND_LOOKUP = 3'd0,
    KIND_PEEK   = 3'd1,
    KIND_INSERT = 3'd2,
    KIND_TICK   = 3'd3,
    KIND_FADE   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] handle;
    logic [31:0] stamp;
    logic [7:0]  fade;
  } row_t;

endpackage

// ===== rtl/core/tlsc_ram.sv =====
// Slot table storage: one row per slot, one write and one registered read port.
// Depends on tlsc_pkg for the row type.
`timescale 1ns / 1ps

module tlsc_ram #(
  parameter int unsigned Depth = tlsc_pkg::SlotsDef,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  tlsc_pkg::row_t       wdata_i,
  input  logic                 re_i,
  input  logic [AddrW-1:0]     raddr_i,
  output tlsc_pkg::row_t       rdata_o
);

  tlsc_pkg::row_t mem_q [Depth];
  tlsc_pkg::row_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/timestamp_lru_slot_cache_top.sv =====
// Timestamp LRU slot cache: item sequencer, slot scan and result register.
// Depends on tlsc_pkg and tlsc_ram.
// Lookup, peek, insert and fade-step items scan the slot table one slot per
// cycle through the single read port of the slot memory, then pass through the
// commit and done states before their result is loaded into the output register.
// Frame ticks, unknown kinds and inserts with a zero handle skip the scan and go
// straight to the done state. The input is ready only while no item is in work.
// A finished result waits in the output register without holding off the next
// item, but a second finished result holds the input off until the first is
// taken. Slot occupancy comes from per-slot valid bits cleared at reset, so no
// clearing pass is needed.
`timescale 1ns / 1ps

module timestamp_lru_slot_cache_top #(
  parameter int unsigned SLOTS = tlsc_pkg::SlotsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,     // fade_step
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,    // key[31:0], handle[63:32]
  input  logic [2:0]  s_axis_tuser,    // kind[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // hit[0], slot[4:1], fade[12:5], found_handle[44:13], evicted[45],
  // evicted_handle[77:46], zero[79:78]
  output logic [79:0] m_axis_tdata
);

  localparam int unsigned IdxW = $clog2(SLOTS);
  localparam int unsigned CntW = $clog2(SLOTS + 1);

  tlsc_pkg::state_e state_q, state_d;

  logic [7:0]      fade_step_q;
  logic [31:0]     frame_q;
  logic [SLOTS-1:0] valid_q;

  logic [2:0]      kind_q;
  logic [31:0]     key_q;
  logic [31:0]     handle_q;

  logic [CntW-1:0] ptr_q;
  logic            rvld_q;
  logic [IdxW-1:0] ev_idx_q;

  logic            found_q;
  logic [IdxW-1:0] found_idx_q;
  tlsc_pkg::row_t  found_row_q;
  logic            empty_q;
  logic [IdxW-1:0] empty_idx_q;
  logic [31:0]     best_stamp_q;
  logic [IdxW-1:0] best_idx_q;
  logic [31:0]     best_handle_q;

  logic            out_vld_q;
  logic [79:0]     out_q;

  logic            accept;
  logic            issue;
  logic            scan_last;
  tlsc_pkg::row_t  rdata;
  logic [31:0]     eff_stamp;
  logic [8:0]      fade_sum;
  logic [7:0]      fade_new;
  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  tlsc_pkg::row_t  ram_wdata;
  logic [IdxW-1:0] victim;
  logic            load_out;
  logic            res_hit;
  logic [IdxW-1:0] res_idx;
  logic [IdxW+3:0] res_idx_ext;
  logic [7:0]      res_fade;
  logic [31:0]     res_handle;
  logic            res_evicted;
  logic [31:0]     res_ev_handle;

  assign s_axis_tready = (state_q == tlsc_pkg::ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign issue         = (state_q == tlsc_pkg::ST_SCAN) && (ptr_q < CntW'(SLOTS));
  assign scan_last     = rvld_q && (ev_idx_q == IdxW'(SLOTS - 1));
  assign eff_stamp     = valid_q[ev_idx_q] ? rdata.stamp : 32'd0;
  assign fade_sum      = {1'b0, rdata.fade} + {1'b0, fade_step_q};
  assign fade_new      = fade_sum[8] ? tlsc_pkg::FadeMax : fade_sum[7:0];
  assign victim        = empty_q ? empty_idx_q : best_idx_q;

  tlsc_ram #(
    .Depth (SLOTS),
    .AddrW (IdxW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (issue),
    .raddr_i (ptr_q[IdxW-1:0]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tlsc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    load_out = 1'b0;
    unique case (state_q)
      tlsc_pkg::ST_IDLE: begin
        if (accept) begin
          case (s_axis_tuser)
            tlsc_pkg::KIND_LOOKUP, tlsc_pkg::KIND_PEEK, tlsc_pkg::KIND_FADE:
              state_d = tlsc_pkg::ST_SCAN;
            tlsc_pkg::KIND_INSERT:
              state_d = (s_axis_tdata[63:32] != 32'd0) ? tlsc_pkg::ST_SCAN
                                                       : tlsc_pkg::ST_DONE;
            default: state_d = tlsc_pkg::ST_DONE;
          endcase
        end
      end
      tlsc_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_d = tlsc_pkg::ST_COMMIT;
        end
      end
      tlsc_pkg::ST_COMMIT: begin
        state_d = tlsc_pkg::ST_DONE;
      end
      tlsc_pkg::ST_DONE: begin
        if (!out_vld_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = tlsc_pkg::ST_IDLE;
        end
      end
      default: state_d = tlsc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fade_step_q <= tlsc_pkg::FadeReset;
      frame_q     <= 32'd0;
      valid_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        fade_step_q <= cfg_wdata_i;
      end
      if (accept && (s_axis_tuser == tlsc_pkg::KIND_TICK)) begin
        frame_q <= frame_q + 32'd1;
      end
      if ((state_q == tlsc_pkg::ST_COMMIT) && (kind_q == tlsc_pkg::KIND_INSERT)) begin
        valid_q[victim] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q   <= s_axis_tuser;
      key_q    <= s_axis_tdata[31:0];
      handle_q <= s_axis_tdata[63:32];
    end
  end

  // slot scan: issue one read per cycle, evaluate the returned row in the following cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q   <= '0;
      rvld_q  <= 1'b0;
      found_q <= 1'b0;
      empty_q <= 1'b0;
    end else begin
      rvld_q <= issue;
      if (accept) begin
        ptr_q   <= '0;
        found_q <= 1'b0;
        empty_q <= 1'b0;
      end else if (issue) begin
        ptr_q <= ptr_q + CntW'(1);
      end
      if (rvld_q) begin
        if (!found_q && (eff_stamp != 32'd0) && (rdata.key == key_q)) begin
          found_q <= 1'b1;
        end
        if (!empty_q && (eff_stamp == 32'd0)) begin
          empty_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      ev_idx_q <= ptr_q[IdxW-1:0];
    end
    if (rvld_q) begin
      if (!found_q && (eff_stamp != 32'd0) && (rdata.key == key_q)) begin
        found_idx_q <= ev_idx_q;
        found_row_q <= rdata;
      end
      if (!empty_q && (eff_stamp == 32'd0)) begin
        empty_idx_q <= ev_idx_q;
      end
      if ((ev_idx_q == '0) || (eff_stamp < best_stamp_q)) begin
        best_stamp_q  <= eff_stamp;
        best_idx_q    <= ev_idx_q;
        best_handle_q <= rdata.handle;
      end
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ev_idx_q;
    ram_wdata = rdata;
    if ((state_q == tlsc_pkg::ST_SCAN) && rvld_q && (kind_q == tlsc_pkg::KIND_FADE)
        && (eff_stamp != 32'd0) && (rdata.fade != tlsc_pkg::FadeMax)) begin
      ram_we         = 1'b1;
      ram_wdata.fade = fade_new;
    end else if (state_q == tlsc_pkg::ST_COMMIT) begin
      if ((kind_q == tlsc_pkg::KIND_LOOKUP) && found_q) begin
        ram_we          = 1'b1;
        ram_waddr       = found_idx_q;
        ram_wdata       = found_row_q;
        ram_wdata.stamp = frame_q;
      end else if (kind_q == tlsc_pkg::KIND_INSERT) begin
        ram_we           = 1'b1;
        ram_waddr        = victim;
        ram_wdata.key    = key_q;
        ram_wdata.handle = handle_q;
        ram_wdata.stamp  = frame_q;
        ram_wdata.fade   = 8'd0;
      end
    end
  end

  always_comb begin
    res_hit       = 1'b0;
    res_idx       = '0;
    res_fade      = 8'd0;
    res_handle    = 32'd0;
    res_evicted   = 1'b0;
    res_ev_handle = 32'd0;
    case (kind_q)
      tlsc_pkg::KIND_LOOKUP, tlsc_pkg::KIND_PEEK: begin
        if (found_q) begin
          res_hit    = 1'b1;
          res_idx    = found_idx_q;
          res_fade   = found_row_q.fade;
          res_handle = found_row_q.handle;
        end
      end
      tlsc_pkg::KIND_INSERT: begin
        if (handle_q != 32'd0) begin
          res_idx = victim;
          if (!empty_q) begin
            res_evicted   = 1'b1;
            res_ev_handle = best_handle_q;
          end
        end
      end
      default: ;
    endcase
  end

  assign res_idx_ext = {4'b0000, res_idx};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load_out) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= {2'b00, res_ev_handle, res_evicted, res_handle, res_fade,
                res_idx_ext[3:0], res_hit};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

`ifndef SYNTHESIS
  a_tick_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (s_axis_tuser == tlsc_pkg::KIND_TICK) |=> frame_q == $past(frame_q) + 32'd1)
    else $error("frame counter did not advance on tick");

  a_hit_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tlsc_pkg::ST_COMMIT) && found_q |->
      (found_row_q.key == key_q) && (found_row_q.stamp != 32'd0))
    else $error("recorded hit does not match key or is empty");

  a_insert_marks_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tlsc_pkg::ST_COMMIT) && (kind_q == tlsc_pkg::KIND_INSERT) |=>
      valid_q[$past(victim)])
    else $error("inserted slot not marked valid");

  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tlsc_pkg::ST_DONE) && out_vld_q && !m_axis_tready |=>
      state_q == tlsc_pkg::ST_DONE)
    else $error("result register overwritten while stalled");
`endif

endmodule

// ===== tb/tb_timestamp_lru_slot_cache_top.sv =====
// Testbench for timestamp_lru_slot_cache_top: directed and random items, checked against
// an in-bench slot table model that predicts every result field.
// Depends on tlsc_pkg and the cache RTL.
`timescale 1ns / 1ps

module tb_timestamp_lru_slot_cache_top;

  localparam int unsigned SLOTS = tlsc_pkg::SlotsDef;
  localparam int unsigned POOL = 24;
  localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
  localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

  class cache_scoreboard;
    logic [31:0] row_key[SLOTS];
    logic [31:0] row_handle[SLOTS];
    logic [31:0] row_stamp[SLOTS];
    logic [7:0]  row_fade[SLOTS];
    logic [31:0] frame_no;
    logic [7:0]  fade_amt;
    logic [79:0] result_q[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned hits;
    int unsigned evictions;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        row_key[i]    = '0;
        row_handle[i] = '0;
        row_stamp[i]  = '0;
        row_fade[i]   = '0;
      end
      frame_no  = '0;
      fade_amt  = tlsc_pkg::FadeReset;
      errors    = 0;
      checked   = 0;
      hits      = 0;
      evictions = 0;
    endfunction

    function void set_fade(logic [7:0] v);
      fade_amt = v;
    endfunction

    function int pending();
      return result_q.size();
    endfunction

    function void note_item(logic [2:0] kind, logic [31:0] key, logic [31:0] handle);
      logic        hit;
      logic [3:0]  slot;
      logic [7:0]  fade;
      logic [31:0] found_handle;
      logic        evicted;
      logic [31:0] evicted_handle;
      logic [31:0] best;
      logic [8:0]  sum;
      int          idx;
      hit = 1'b0;
      slot = '0;
      fade = '0;
      found_handle = '0;
      evicted = 1'b0;
      evicted_handle = '0;
      idx = -1;
      case (kind)
        tlsc_pkg::KIND_LOOKUP, tlsc_pkg::KIND_PEEK: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (idx < 0 && row_stamp[i] != 0 && row_key[i] == key) idx = i;
          end
          if (idx >= 0) begin
            if (kind == tlsc_pkg::KIND_LOOKUP) row_stamp[idx] = frame_no;
            hit = 1'b1;
            slot = idx[3:0];
            fade = row_fade[idx];
            found_handle = row_handle[idx];
            hits++;
          end
        end
        tlsc_pkg::KIND_INSERT: begin
          if (handle != 0) begin
            best = 32'hFFFF_FFFF;
            idx = 0;
            for (int i = 0; i < SLOTS; i++) begin
              if (row_stamp[i] == 0) begin
                idx = i;
                break;
              end
              if (row_stamp[i] < best) begin
                best = row_stamp[i];
                idx = i;
              end
            end
            if (row_stamp[idx] != 0) begin
              evicted = 1'b1;
              evicted_handle = row_handle[idx];
              evictions++;
            end
            row_key[idx]    = key;
            row_handle[idx] = handle;
            row_stamp[idx]  = frame_no;
            row_fade[idx]   = '0;
            slot = idx[3:0];
          end
        end
        tlsc_pkg::KIND_TICK: frame_no = frame_no + 32'd1;
        tlsc_pkg::KIND_FADE: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (row_stamp[i] != 0 && row_fade[i] != tlsc_pkg::FadeMax) begin
              sum = {1'b0, row_fade[i]} + {1'b0, fade_amt};
              row_fade[i] = sum[8] ? tlsc_pkg::FadeMax : sum[7:0];
            end
          end
        end
        default: ;
      endcase
      result_q.push_back({2'b00, evicted_handle, evicted, found_handle, fade, slot, hit});
    endfunction

    function void cmp_field(string name, logic [31:0] exp, logic [31:0] got);
      if (exp !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp, got);
      end
    endfunction

    function void check_result(logic [79:0] got);
      logic [79:0] exp;
      checked++;
      if (result_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, expected none, actual %h", $time, got);
        return;
      end
      exp = result_q.pop_front();
      cmp_field("hit", exp[0], got[0]);
      cmp_field("slot", exp[4:1], got[4:1]);
      cmp_field("fade", exp[12:5], got[12:5]);
      cmp_field("found_handle", exp[44:13], got[44:13]);
      cmp_field("evicted", exp[45], got[45]);
      cmp_field("evicted_handle", exp[77:46], got[77:46]);
      cmp_field("pad", exp[79:78], got[79:78]);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [7:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // key[31:0], handle[63:32]
  logic [2:0]  s_axis_tuser = '0;   // kind[2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // hit[0], slot[4:1], fade[12:5], found_handle[44:13], evicted[45],
  // evicted_handle[77:46], zero[79:78]
  logic [79:0] m_axis_tdata;

  cache_scoreboard sb;
  logic [31:0] key_pool[POOL];
  int unsigned burst_left = 0;
  int unsigned items_sent = 0;
  bit          hold_req = 1'b0;
  int unsigned long_holds = 0;

  timestamp_lru_slot_cache_top #(
    .SLOTS(SLOTS)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20000000;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // receiver: random stretches of steady, patchy, heavy and light stall, plus requested long hold
  initial begin
    int mode;
    int len;
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (600) @(posedge clk_i);
        hold_req = 1'b0;
        long_holds++;
      end
      mode = $urandom_range(0, 3);
      len = $urandom_range(1, 64);
      repeat (len) begin
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  task automatic send_item(input logic [2:0] kind, input logic [31:0] key,
                           input logic [31:0] handle);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {handle, key};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(kind, key, handle);
    items_sent++;
  endtask

  task automatic drain();
    int unsigned n;
    n = 0;
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0 && n < 200000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (SLOTS + 8) @(posedge clk_i);
  endtask

  task automatic set_fade(input logic [7:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    sb.set_fade(v);
    cfg_we_i <= 1'b0;
  endtask

  task automatic rand_item(output bit counted);
    int unsigned r;
    logic [2:0]  kind;
    logic [31:0] key;
    logic [31:0] handle;
    r = $urandom_range(0, 99);
    key = ($urandom_range(0, 9) != 0) ? key_pool[$urandom_range(0, POOL - 1)] : $urandom;
    handle = $urandom;
    if (handle == 0) handle = 32'd1;
    if (r < 30) kind = tlsc_pkg::KIND_LOOKUP;
    else if (r < 40) kind = tlsc_pkg::KIND_PEEK;
    else if (r < 64) kind = tlsc_pkg::KIND_INSERT;
    else if (r < 66) begin
      kind = tlsc_pkg::KIND_INSERT;
      handle = '0;
    end
    else if (r < 80) kind = tlsc_pkg::KIND_TICK;
    else if (r < 89) kind = tlsc_pkg::KIND_FADE;
    else if (r < 93) kind = 3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
    else begin
      kind = 3'($urandom_range(0, 7));
      key = $urandom;
      handle = $urandom;
    end
    counted = (kind <= tlsc_pkg::KIND_FADE) && !(kind == tlsc_pkg::KIND_INSERT && handle == 0);
    send_item(kind, key, handle);
  endtask

  task automatic run_phase(input int unsigned n, input bit with_hold);
    int unsigned done;
    bit          counted;
    done = 0;
    while (done < n) begin
      if (with_hold && done == n / 3) hold_req = 1'b1;
      rand_item(counted);
      if (counted) done++;
    end
  endtask

  initial begin
    logic [7:0] fade_plan[6];
    sb = new();
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL; i++) key_pool[i] = $urandom;
    fade_plan[0] = 8'd255;
    fade_plan[1] = 8'd0;
    fade_plan[2] = 8'd1;
    fade_plan[3] = 8'($urandom_range(0, 255));
    fade_plan[4] = 8'd200;
    fade_plan[5] = tlsc_pkg::FadeReset;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(tlsc_pkg::KIND_LOOKUP, 32'h0000_0000, 32'h0);
    send_item(tlsc_pkg::KIND_PEEK, 32'hFFFF_FFFF, 32'h0);
    send_item(tlsc_pkg::KIND_INSERT, 32'h1234_5678, 32'hA5A5_A5A5);
    send_item(tlsc_pkg::KIND_LOOKUP, 32'h1234_5678, 32'h0);
    send_item(tlsc_pkg::KIND_INSERT, 32'h0000_0000, 32'h0);
    send_item(tlsc_pkg::KIND_TICK, $urandom, $urandom);
    send_item(tlsc_pkg::KIND_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(tlsc_pkg::KIND_INSERT, 32'hFFFF_FFFF, 32'h0000_0001);
    send_item(tlsc_pkg::KIND_INSERT, 32'h0000_0000, 32'h0000_0002);
    send_item(tlsc_pkg::KIND_LOOKUP, 32'h0000_0000, 32'h0);
    send_item(tlsc_pkg::KIND_FADE, $urandom, $urandom);
    send_item(tlsc_pkg::KIND_FADE, $urandom, $urandom);
    send_item(tlsc_pkg::KIND_PEEK, 32'hFFFF_FFFF, 32'h0);
    for (int k = KIND_UNUSED_LO; k <= KIND_UNUSED_HI; k++) send_item(3'(k), $urandom, $urandom);
    send_item(tlsc_pkg::KIND_TICK, 32'h0, 32'h0);
    send_item(tlsc_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    send_item(tlsc_pkg::KIND_INSERT, 32'h5A5A_5A5A, 32'h8000_0000);
    send_item(tlsc_pkg::KIND_LOOKUP, 32'h1234_5678, 32'h0);

    for (int p = 0; p < 6; p++) begin
      set_fade(fade_plan[p]);
      run_phase(265, p == 1);
    end
    drain();

    $display("checked %0d results from %0d items: %0d hits, %0d evictions, %0d long stall(s)",
             sb.checked, items_sent, sb.hits, sb.evictions, long_holds);
    $display("fade steps used: 22, 255, 0, 1, %0d, 200, 22", fade_plan[3]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches, %0d results never arrived", sb.errors, sb.pending());
      $display("tb: failure");
    end
    $finish;
  end

endmodule
